### rtl/drc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the dirty rectangle coalescer: default
// screen and table sizes, item kinds and the layout of one output beat.
// ----------------------------------------------------------------------------
package drc_pkg;

	localparam int SCREEN_WIDTH_DEF  = 160;
	localparam int SCREEN_HEIGHT_DEF = 128;
	localparam int MAX_RECTS_DEF     = 8;

	// output field widths are fixed by the port list
	localparam int RECT_X_W = 8;
	localparam int RECT_Y_W = 7;
	localparam int RECT_W_W = 8;
	localparam int RECT_H_W = 8;

	localparam logic KIND_MARK  = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic [RECT_X_W-1:0] x;
		logic [RECT_Y_W-1:0] y;
		logic [RECT_W_W-1:0] w;
		logic [RECT_H_W-1:0] h;
		logic                last;
	} rect_beat_t;

endpackage
`default_nettype wire

### rtl/drc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drc_ram
// Generic single write port, single read port RAM with a registered read.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
module drc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = drc_pkg::MAX_RECTS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/drc_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drc_out_reg
// Output register of the drain path. Holds one beat until the receiver
// takes it and reports when a new beat may be loaded.
// ----------------------------------------------------------------------------
module drc_out_reg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire drc_pkg::rect_beat_t               din,
	output logic                                   free,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [drc_pkg::RECT_X_W-1:0]      rect_x,
	output logic      [drc_pkg::RECT_Y_W-1:0]      rect_y,
	output logic      [drc_pkg::RECT_W_W-1:0]      rect_w,
	output logic      [drc_pkg::RECT_H_W-1:0]      rect_h,
	output logic                                   last
);

	logic                valid_q;
	drc_pkg::rect_beat_t beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= din;
		end
	end

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign rect_x    = beat_q.x;
	assign rect_y    = beat_q.y;
	assign rect_w    = beat_q.w;
	assign rect_h    = beat_q.h;
	assign last      = beat_q.last;

endmodule
`default_nettype wire

### rtl/dirty_rect_coalescer.sv
`default_nettype none
// mark: accept, one read per stored entry, a check of the last entry read and
//   the write-back; a hit ends it early, an empty table goes to the write-back
// dropped mark or empty drain: the block stays idle; drain: table read, then
//   output register, one beat per cycle unless stalled (single table read port)
// reset clears the entry count and the control state, table contents are left
// as they are and need no clearing pass
// ----------------------------------------------------------------------------
// dirty_rect_coalescer
// Keeps a small table of dirty screen rectangles in a RAM. Marks are clipped
// and merged into the first touching entry, appended, or collapse the full
// table into one box. A drain streams the entries out and empties the table.
// ----------------------------------------------------------------------------
module dirty_rect_coalescer #(
	parameter int SCREEN_WIDTH  = drc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = drc_pkg::SCREEN_HEIGHT_DEF,
	parameter int MAX_RECTS     = drc_pkg::MAX_RECTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         kind,
	input  wire logic [15:0]                  req_x,
	input  wire logic [15:0]                  req_y,
	input  wire logic [15:0]                  req_w,
	input  wire logic [15:0]                  req_h,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [drc_pkg::RECT_X_W-1:0] rect_x,
	output logic      [drc_pkg::RECT_Y_W-1:0] rect_y,
	output logic      [drc_pkg::RECT_W_W-1:0] rect_w,
	output logic      [drc_pkg::RECT_H_W-1:0] rect_h,
	output logic                              last
);

	localparam int XW = $clog2(SCREEN_WIDTH + 1);
	localparam int YW = $clog2(SCREEN_HEIGHT + 1);
	localparam int EW = 2 * XW + 2 * YW;
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECTS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MARK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_s1;
	logic          pend_s1;

	// incoming box as edges, and the running bounding box of the scan
	logic [XW-1:0] nb_x0_q, nb_x1_q, acc_x0_q, acc_x1_q;
	logic [YW-1:0] nb_y0_q, nb_y1_q, acc_y0_q, acc_y1_q;

	logic          in_acc;
	logic          drop;
	logic [16:0]   sum_x, sum_y;
	logic [XW-1:0] clip_x1;
	logic [YW-1:0] clip_y1;

	logic [EW-1:0] rdata;
	logic [XW-1:0] r_x, r_w, r_x1;
	logic [YW-1:0] r_y, r_h, r_y1;
	logic          touch;
	logic [XW-1:0] g_x0, g_x1, u_x0, u_x1;
	logic [YW-1:0] g_y0, g_y1, u_y0, u_y1;

	logic          is_mark, is_drain, more, full;
	logic          hit, m_issue, m_done;
	logic          d_load, d_issue, d_last;
	logic          out_free;

	logic          rd_en, wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	drc_pkg::rect_beat_t beat;

	// ------------------------------------------------------------------
	// input clip
	// ------------------------------------------------------------------
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign sum_x = {1'b0, req_x} + {1'b0, req_w};
	assign sum_y = {1'b0, req_y} + {1'b0, req_h};

	assign drop = (req_w == 16'd0) || (req_h == 16'd0) ||
		(req_x >= 16'(SCREEN_WIDTH)) || (req_y >= 16'(SCREEN_HEIGHT));

	assign clip_x1 = (sum_x > 17'(SCREEN_WIDTH))  ? XW'(SCREEN_WIDTH)  : sum_x[XW-1:0];
	assign clip_y1 = (sum_y > 17'(SCREEN_HEIGHT)) ? YW'(SCREEN_HEIGHT) : sum_y[YW-1:0];

	// ------------------------------------------------------------------
	// table entry decode, entry layout is {x, y, w, h}
	// ------------------------------------------------------------------
	assign r_x  = rdata[EW-1 -: XW];
	assign r_y  = rdata[XW+2*YW-1 -: YW];
	assign r_w  = rdata[XW+YW-1 -: XW];
	assign r_h  = rdata[YW-1:0];
	assign r_x1 = r_x + r_w;
	assign r_y1 = r_y + r_h;

	// sharing an edge or a corner counts as touching
	assign touch = !((r_x1 < nb_x0_q) || (nb_x1_q < r_x) ||
		(r_y1 < nb_y0_q) || (nb_y1_q < r_y));

	assign g_x0 = (r_x  < nb_x0_q) ? r_x  : nb_x0_q;
	assign g_y0 = (r_y  < nb_y0_q) ? r_y  : nb_y0_q;
	assign g_x1 = (r_x1 > nb_x1_q) ? r_x1 : nb_x1_q;
	assign g_y1 = (r_y1 > nb_y1_q) ? r_y1 : nb_y1_q;

	assign u_x0 = (r_x  < acc_x0_q) ? r_x  : acc_x0_q;
	assign u_y0 = (r_y  < acc_y0_q) ? r_y  : acc_y0_q;
	assign u_x1 = (r_x1 > acc_x1_q) ? r_x1 : acc_x1_q;
	assign u_y1 = (r_y1 > acc_y1_q) ? r_y1 : acc_y1_q;

	// ------------------------------------------------------------------
	// sequencer control
	// ------------------------------------------------------------------
	assign is_mark  = (state_q == ST_MARK);
	assign is_drain = (state_q == ST_DRAIN);
	assign more     = (idx_q < count_q);
	assign full     = (count_q == CNT_MAX);

	// reads run one entry ahead of the touch check; a hit stops further reads
	assign hit     = is_mark && pend_s1 && touch;
	assign m_issue = is_mark && !hit && more;
	assign m_done  = is_mark && !hit && !more && !pend_s1;

	// read data is held in the RAM until the output register takes it
	assign d_load  = is_drain && pend_s1 && out_free;
	assign d_issue = is_drain && more && (!pend_s1 || d_load);
	assign d_last  = (idx_s1 == count_q - CW'(1));

	assign rd_en = m_issue || d_issue;
	assign wr_en = hit || m_done;

	// writes happen only on the last cycle of a mark, so no read can overlap them
	always_comb begin
		priority if (hit) begin
			wr_addr = idx_s1[AW-1:0];
			wr_data = {g_x0, g_y0, g_x1 - g_x0, g_y1 - g_y0};
		end else if (full) begin
			wr_addr = '0;
			wr_data = {acc_x0_q, acc_y0_q, acc_x1_q - acc_x0_q, acc_y1_q - acc_y0_q};
		end else begin
			wr_addr = count_q[AW-1:0];
			wr_data = {nb_x0_q, nb_y0_q, nb_x1_q - nb_x0_q, nb_y1_q - nb_y0_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			idx_s1  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						if (kind == drc_pkg::KIND_DRAIN) begin
							if (count_q != '0) begin
								state_q <= ST_DRAIN;
							end
						end else if (!drop) begin
							state_q <= ST_MARK;
						end
					end
				end
				ST_MARK: begin
					pend_s1 <= m_issue;
					if (m_issue) begin
						idx_q  <= idx_q + CW'(1);
						idx_s1 <= idx_q;
					end
					if (hit) begin
						state_q <= ST_IDLE;
					end
					if (m_done) begin
						state_q <= ST_IDLE;
						count_q <= full ? CW'(1) : count_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					pend_s1 <= d_issue || (pend_s1 && !d_load);
					if (d_issue) begin
						idx_q  <= idx_q + CW'(1);
						idx_s1 <= idx_q;
					end
					if (d_load && d_last) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			nb_x0_q  <= req_x[XW-1:0];
			nb_y0_q  <= req_y[YW-1:0];
			nb_x1_q  <= clip_x1;
			nb_y1_q  <= clip_y1;
			acc_x0_q <= req_x[XW-1:0];
			acc_y0_q <= req_y[YW-1:0];
			acc_x1_q <= clip_x1;
			acc_y1_q <= clip_y1;
		end else if (is_mark && pend_s1) begin
			// bounding box of everything scanned, used when the table is full
			acc_x0_q <= u_x0;
			acc_y0_q <= u_y0;
			acc_x1_q <= u_x1;
			acc_y1_q <= u_y1;
		end
	end

	// ------------------------------------------------------------------
	// table and output register
	// ------------------------------------------------------------------
	drc_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_RECTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		beat.x    = drc_pkg::RECT_X_W'(r_x);
		beat.y    = drc_pkg::RECT_Y_W'(r_y);
		beat.w    = drc_pkg::RECT_W_W'(r_w);
		beat.h    = drc_pkg::RECT_H_W'(r_h);
		beat.last = d_last;
	end

	drc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (d_load),
		.din       (beat),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rect_x    (rect_x),
		.rect_y    (rect_y),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.last      (last)
	);

endmodule
`default_nettype wire

### rtl/drc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks of the dirty rectangle coalescer, bound to the top level.
// ----------------------------------------------------------------------------
module drc_checker #(
	parameter int SCREEN_WIDTH  = drc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = drc_pkg::SCREEN_HEIGHT_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         kind,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [drc_pkg::RECT_X_W-1:0] rect_x,
	input wire logic [drc_pkg::RECT_Y_W-1:0] rect_y,
	input wire logic [drc_pkg::RECT_W_W-1:0] rect_w,
	input wire logic [drc_pkg::RECT_H_W-1:0] rect_h,
	input wire logic                         last
);

	// geometry check only where the output ports hold the full values
	localparam logic GEOM_OK = (SCREEN_WIDTH < 256) && (SCREEN_HEIGHT <= 128);

	logic [8:0] x_end;
	logic [8:0] y_end;

	assign x_end = {1'b0, rect_x} + {1'b0, rect_w};
	assign y_end = {2'b0, rect_y} + {1'b0, rect_h};

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(rect_y) &&
			$stable(rect_w) && $stable(rect_h) && $stable(last))
		else $error("stalled output beat changed");

	// beats only start while a drain is in progress
	a_out_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output beat started outside a drain");

	// input stays closed while a drain shows a beat other than its last one
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open while a drain is unfinished");

	// every drained box is non-empty and lies on screen
	a_geom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && GEOM_OK |-> (rect_w != '0) && (rect_h != '0) &&
			(x_end <= 9'(SCREEN_WIDTH)) && (y_end <= 9'(SCREEN_HEIGHT)))
		else $error("drained rectangle off screen or empty");

	// a drain item is never taken while a non-last beat of a drain is on the output
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == drc_pkg::KIND_DRAIN) |-> !(out_valid && !last))
		else $error("drain accepted during a drain");

endmodule

bind dirty_rect_coalescer drc_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_drc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.rect_x    (rect_x),
	.rect_y    (rect_y),
	.rect_w    (rect_w),
	.rect_h    (rect_h),
	.last      (last)
);
`default_nettype wire

### test/dirty_rect_coalescer_tb.sv
// ----------------------------------------------------------------------------
// dirty_rect_coalescer_tb
// Drives marks and drains into the coalescer with random gaps and output
// stalls. A table walk of corner cases comes first, then random bursts of
// marks, each closed by a drain. Drained rectangles are checked against a local
// dirty table copy kept in step with accepted items, or on EXP_SINGLE rows the row.
// ----------------------------------------------------------------------------
module dirty_rect_coalescer_tb;

	localparam int SCR_W      = drc_pkg::SCREEN_WIDTH_DEF;
	localparam int SCR_H      = drc_pkg::SCREEN_HEIGHT_DEF;
	localparam int RECTS      = drc_pkg::MAX_RECTS_DEF;
	localparam int NUM_DIR    = 25;
	localparam int RAND_ITEMS = 100;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL       = 30;

	typedef enum logic [1:0] {EXP_PREDICTED, EXP_NONE, EXP_SINGLE} exp_mode_t;

	// on EXP_SINGLE drain rows the payload holds the expected rectangle
	typedef struct packed {
		logic        kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		exp_mode_t   mode;
	} stim_row_t;

	typedef struct packed {
		logic [8:0] x;
		logic [8:0] y;
		logic [8:0] w;
		logic [8:0] h;
	} area_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [15:0] req_x;
	logic [15:0] req_y;
	logic [15:0] req_w;
	logic [15:0] req_h;
	logic        out_valid;
	logic        out_stall;
	logic [drc_pkg::RECT_X_W-1:0] rect_x;
	logic [drc_pkg::RECT_Y_W-1:0] rect_y;
	logic [drc_pkg::RECT_W_W-1:0] rect_w;
	logic [drc_pkg::RECT_H_W-1:0] rect_h;
	logic        last;

	area_t               rect_tab [RECTS];
	int                  rect_cnt;
	drc_pkg::rect_beat_t drain_buf [RECTS];
	drc_pkg::rect_beat_t rects_due [$];
	stim_row_t           dir_rows [NUM_DIR];

	int items_sent;
	int items_used;
	int items_ignored;
	int drains_done;
	int collapses;
	int rects_seen;
	int mismatches;
	int idle_cycles;

	dirty_rect_coalescer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.req_x     (req_x),
		.req_y     (req_y),
		.req_w     (req_w),
		.req_h     (req_h),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rect_x    (rect_x),
		.rect_y    (rect_y),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.last      (last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic area_t bounding_box(area_t a, area_t b);
		logic [8:0] x0;
		logic [8:0] y0;
		logic [8:0] x1;
		logic [8:0] y1;
		x0 = (a.x < b.x) ? a.x : b.x;
		y0 = (a.y < b.y) ? a.y : b.y;
		x1 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
		y1 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
		return {x0, y0, 9'(x1 - x0), 9'(y1 - y0)};
	endfunction

	// updates the local table; returns beats drained, 0 for a mark that
	// changed the table, -1 for an item the block ignores
	function automatic int track_dirty(logic k, logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] h);
		area_t       nb;
		int unsigned cx;
		int unsigned cy;
		int unsigned cw;
		int unsigned ch;
		int          n;
		if (k == drc_pkg::KIND_DRAIN) begin
			if (rect_cnt == 0)
				return -1;
			n = rect_cnt;
			for (int i = 0; i < n; i++)
				drain_buf[i] = {rect_tab[i].x[7:0], rect_tab[i].y[6:0],
					rect_tab[i].w[7:0], rect_tab[i].h[7:0], 1'(i == n - 1)};
			rect_cnt = 0;
			return n;
		end
		cx = 32'(x);
		cy = 32'(y);
		cw = 32'(w);
		ch = 32'(h);
		if (cw == 0 || ch == 0 || cx >= SCR_W || cy >= SCR_H)
			return -1;
		if (cx + cw > SCR_W)
			cw = SCR_W - cx;
		if (cy + ch > SCR_H)
			ch = SCR_H - cy;
		nb = {9'(cx), 9'(cy), 9'(cw), 9'(ch)};
		// first entry that overlaps or shares an edge or corner takes it
		for (int i = 0; i < rect_cnt; i++) begin
			if (!(rect_tab[i].x + rect_tab[i].w < nb.x || nb.x + nb.w < rect_tab[i].x ||
					rect_tab[i].y + rect_tab[i].h < nb.y || nb.y + nb.h < rect_tab[i].y)) begin
				rect_tab[i] = bounding_box(rect_tab[i], nb);
				return 0;
			end
		end
		if (rect_cnt < RECTS) begin
			rect_tab[rect_cnt] = nb;
			rect_cnt++;
			return 0;
		end
		// full table folds into entry 0
		for (int i = 1; i < rect_cnt; i++)
			rect_tab[0] = bounding_box(rect_tab[0], rect_tab[i]);
		rect_tab[0] = bounding_box(rect_tab[0], nb);
		rect_cnt = 1;
		collapses++;
		return 0;
	endfunction

	task automatic send_item(logic k, logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] h, exp_mode_t mode);
		int gap;
		int n;
		gap = ((items_sent % 40) < 10) ? 0 : $urandom_range(0, 12);
		// valid stays high across back-to-back beats
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		req_x    <= x;
		req_y    <= y;
		req_w    <= w;
		req_h    <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		n = track_dirty(k, x, y, w, h);
		if (n < 0)
			items_ignored++;
		else
			items_used++;
		if (n > 0)
			drains_done++;
		if (mode == EXP_PREDICTED) begin
			for (int i = 0; i < n; i++)
				rects_due.push_back(drain_buf[i]);
		end else if (mode == EXP_SINGLE) begin
			rects_due.push_back({x[7:0], y[6:0], w[7:0], h[7:0], 1'b1});
		end
	endtask

	task automatic send_random_mark();
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		int          sel;
		sel = $urandom_range(0, 9);
		x = 16'($urandom_range(0, SCR_W - 1));
		y = 16'($urandom_range(0, SCR_H - 1));
		w = 16'($urandom_range(1, 12));
		h = 16'($urandom_range(1, 12));
		case (sel)
			5: begin
				w = 16'($urandom_range(1, 64));
				h = 16'($urandom_range(1, 64));
			end
			6: begin
				// runs past the right and bottom edges
				x = 16'($urandom_range(100, SCR_W - 1));
				y = 16'($urandom_range(80, SCR_H - 1));
				w = 16'($urandom);
				h = 16'($urandom);
			end
			7: begin
				x = 16'($urandom);
				y = 16'($urandom);
				w = 16'($urandom);
				h = 16'($urandom);
			end
			8: begin
				w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
				h = (w == 0) ? 16'($urandom) : 16'd0;
			end
			9: begin
				if ($urandom_range(0, 1))
					x = 16'($urandom_range(SCR_W, 65535));
				else
					y = 16'($urandom_range(SCR_H, 65535));
			end
			default: begin
			end
		endcase
		send_item(drc_pkg::KIND_MARK, x, y, w, h, EXP_PREDICTED);
	endtask

	// output side: random stall ahead of each beat, with calm stretches
	initial begin : out_side
		int n;
		int taken;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = ((taken % 32) < 8) ? 0 : $urandom_range(0, 12);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid || out_stall)
				@(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin : check_beats
		drc_pkg::rect_beat_t got;
		drc_pkg::rect_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {rect_x, rect_y, rect_w, rect_h, last};
			rects_seen++;
			if (rects_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected rect beat x=%0d y=%0d w=%0d h=%0d last=%0b",
					$time, got.x, got.y, got.w, got.h, got.last);
			end else begin
				want = rects_due.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: rect beat expected x=%0d y=%0d w=%0d h=%0d last=%0b",
						$time, want.x, want.y, want.w, want.h, want.last);
					$display("%0t:            got x=%0d y=%0d w=%0d h=%0d last=%0b",
						$time, got.x, got.y, got.w, got.h, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d rectangles still due",
				$time, IDLE_LIMIT, rects_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int target;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		kind          <= drc_pkg::KIND_MARK;
		req_x         <= '0;
		req_y         <= '0;
		req_w         <= '0;
		req_h         <= '0;
		idle_cycles   = 0;
		rect_cnt      = 0;
		items_sent    = 0;
		items_used    = 0;
		items_ignored = 0;
		drains_done   = 0;
		collapses     = 0;
		rects_seen    = 0;
		mismatches    = 0;
		dir_rows = '{
			'{drc_pkg::KIND_DRAIN, 16'd0,    16'd0,    16'd0,    16'd0,    EXP_NONE},
			'{drc_pkg::KIND_MARK,  16'd0,    16'd0,    16'd1,    16'd1,    EXP_PREDICTED},
			'{drc_pkg::KIND_DRAIN, 16'd0,    16'd0,    16'd1,    16'd1,    EXP_SINGLE},
			'{drc_pkg::KIND_MARK,  16'd5,    16'd5,    16'd0,    16'd10,   EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd5,    16'd5,    16'd10,   16'd0,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd160,  16'd0,    16'd4,    16'd4,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd0,    16'd128,  16'd4,    16'd4,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, EXP_PREDICTED},
			'{drc_pkg::KIND_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, EXP_NONE},
			'{drc_pkg::KIND_MARK,  16'd0,    16'd0,    16'hFFFF, 16'hFFFF, EXP_PREDICTED},
			'{drc_pkg::KIND_DRAIN, 16'd0,    16'd0,    16'd160,  16'd128,  EXP_SINGLE},
			'{drc_pkg::KIND_MARK,  16'd159,  16'd127,  16'hFFFF, 16'hFFFF, EXP_PREDICTED},
			'{drc_pkg::KIND_DRAIN, 16'd159,  16'd127,  16'd1,    16'd1,    EXP_SINGLE},
			// shared edge, then shared corner
			'{drc_pkg::KIND_MARK,  16'd10,   16'd10,   16'd5,    16'd5,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd15,   16'd10,   16'd5,    16'd5,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd40,   16'd40,   16'd4,    16'd4,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd44,   16'd44,   16'd2,    16'd2,    EXP_PREDICTED},
			// fill the table, the last mark folds everything into one box
			'{drc_pkg::KIND_MARK,  16'd0,    16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd20,   16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd40,   16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd60,   16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd80,   16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd100,  16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_MARK,  16'd120,  16'd100,  16'd2,    16'd2,    EXP_PREDICTED},
			'{drc_pkg::KIND_DRAIN, 16'd0,    16'd0,    16'd0,    16'd0,    EXP_PREDICTED}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++)
			send_item(dir_rows[i].kind, dir_rows[i].x, dir_rows[i].y,
				dir_rows[i].w, dir_rows[i].h, dir_rows[i].mode);

		// bursts of marks, each closed by a drain, now and then a second empty one
		target = items_used + RAND_ITEMS;
		while (items_used < target) begin
			repeat ($urandom_range(1, 14))
				send_random_mark();
			send_item(drc_pkg::KIND_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), EXP_PREDICTED);
			if ($urandom_range(0, 5) == 0)
				send_item(drc_pkg::KIND_DRAIN, 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), EXP_PREDICTED);
		end
		send_item(drc_pkg::KIND_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), EXP_PREDICTED);
		in_valid <= 1'b0;

		while (rects_due.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		$display("%0d items sent, %0d of them ignored; %0d drains, %0d full-table folds",
			items_sent, items_ignored, drains_done, collapses);
		$display("%0d drained rectangles compared", rects_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
